>>> src/frli_pkg.sv
// Package for the flash ring log index: geometry constants, operation codes
// and the result record type. No dependencies; every other file imports it.

package frli_pkg;

  // Flash geometry. Slot and block arithmetic below relies on powers of two.
  localparam int NUM_BLOCKS   = 128;
  localparam int BLOCK_BYTES  = 65536;
  localparam int RECORD_BYTES = 16;

  localparam int SLOTS    = BLOCK_BYTES / RECORD_BYTES;
  localparam int CAPACITY = NUM_BLOCKS * SLOTS;

  localparam int BLK_W  = $clog2(NUM_BLOCKS);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int REC_W  = $clog2(RECORD_BYTES);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  // Field widths of the channels.
  localparam int INDEX_W = 19;
  localparam int ADDR_W  = 23;
  localparam int EBLK_W  = 7;
  localparam int COUNT_W = 20;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef struct packed {
    logic               ok;
    logic [ADDR_W-1:0]  address;
    logic               erase_request;
    logic [EBLK_W-1:0]  erase_block;
    logic [COUNT_W-1:0] record_count;
    logic [COUNT_W-1:0] remaining;
  } res_t;

endpackage

>>> src/frli_if.sv
// Channel interfaces of the flash ring log index: input items and results.
// Depends on frli_pkg for field widths.

interface frli_in_if import frli_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [INDEX_W-1:0] index;

  modport source (output valid, output op, output index, input ready);
  modport sink   (input valid, input op, input index, output ready);
endinterface

interface frli_out_if import frli_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               ok;
  logic [ADDR_W-1:0]  address;
  logic               erase_request;
  logic [EBLK_W-1:0]  erase_block;
  logic [COUNT_W-1:0] record_count;
  logic [COUNT_W-1:0] remaining;

  modport source (output valid, output ok, output address, output erase_request,
                  output erase_block, output record_count, output remaining,
                  input ready);
  modport sink   (input valid, input ok, input address, input erase_request,
                  input erase_block, input record_count, input remaining,
                  output ready);
endinterface

>>> src/flash_ring_log_index.sv
// Top level of the flash ring log index: input register, pointer logic and
// result register. Depends on frli_pkg, frli_if.sv and frli_ptr.
//
//   channel   direction  handshake       payload
//   in_chan   sink       valid / ready   op, index
//   out_chan  source     valid / ready   ok, address, erase_request,
//                                        erase_block, record_count, remaining
//
// Each item waits in the input register, where the pointer logic works on it,
// and then lands in the result register; one item is taken per cycle while
// out_chan takes results. Reset clears both valid flags and all pointers.
// While a result is held back, the input register holds its item and the
// pointers stay put, so in_chan.ready drops once both registers are full.

module flash_ring_log_index import frli_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  frli_in_if.sink    in_chan,
  frli_out_if.source out_chan
);

  logic               in_valid_r;
  logic               in_op_r;
  logic [INDEX_W-1:0] in_index_r;
  logic               out_valid_r;
  res_t               out_res_r;
  res_t               res;
  logic               advance;

  // The item in the input register moves on when the result slot frees up.
  assign advance       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_op_r    <= in_chan.op;
      in_index_r <= in_chan.index;
    end
  end

  frli_ptr u_ptr (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .op    (in_op_r),
    .index (in_index_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.ok            = out_res_r.ok;
  assign out_chan.address       = out_res_r.address;
  assign out_chan.erase_request = out_res_r.erase_request;
  assign out_chan.erase_block   = out_res_r.erase_block;
  assign out_chan.record_count  = out_res_r.record_count;
  assign out_chan.remaining     = out_res_r.remaining;

endmodule

>>> src/frli_ptr.sv
// Write/oldest pointers and record count of the log, with the single-pass
// append and lookup logic. Depends on frli_pkg.

module frli_ptr import frli_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               op,
  input  logic [INDEX_W-1:0] index,
  output res_t               res
);

  logic [BLK_W-1:0]  write_block_r, write_block_nxt;
  logic [SLOT_W-1:0] write_slot_r, write_slot_nxt;
  logic [BLK_W-1:0]  oldest_block_r, oldest_block_nxt;
  logic [SLOT_W-1:0] oldest_slot_r, oldest_slot_nxt;
  logic [CNT_W-1:0]  record_total_r, record_total_nxt;

  logic              full;
  logic              in_range;
  logic [INDEX_W:0]  off;
  logic [BLK_W-1:0]  look_blk;
  logic [SLOT_W-1:0] look_slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_block_r  <= '0;
      write_slot_r   <= '0;
      oldest_block_r <= '0;
      oldest_slot_r  <= '0;
      record_total_r <= '0;
    end else if (step) begin
      write_block_r  <= write_block_nxt;
      write_slot_r   <= write_slot_nxt;
      oldest_block_r <= oldest_block_nxt;
      oldest_slot_r  <= oldest_slot_nxt;
      record_total_r <= record_total_nxt;
    end
  end

  assign full     = (record_total_r == CNT_W'(CAPACITY));
  assign in_range = (CNT_W'(index) < record_total_r);

  // Lookup: the logical index counts slots forward from the oldest record.
  assign off       = (INDEX_W+1)'(oldest_slot_r) + (INDEX_W+1)'(index);
  assign look_slot = off[SLOT_W-1:0];
  assign look_blk  = oldest_block_r + BLK_W'(off >> SLOT_W);

  always_comb begin
    write_block_nxt   = write_block_r;
    write_slot_nxt    = write_slot_r;
    oldest_block_nxt  = oldest_block_r;
    oldest_slot_nxt   = oldest_slot_r;
    record_total_nxt  = record_total_r;
    res.ok            = 1'b0;
    res.address       = '0;
    res.erase_request = 1'b0;
    res.erase_block   = '0;

    if (op == OP_APPEND) begin
      res.ok      = 1'b1;
      res.address = ADDR_W'({write_block_r, write_slot_r, REC_W'(0)});
      if (write_slot_r == SLOT_W'(SLOTS - 1)) begin
        write_slot_nxt    = '0;
        write_block_nxt   = write_block_r + BLK_W'(1);
        res.erase_request = 1'b1;
        res.erase_block   = EBLK_W'(write_block_nxt);
      end else begin
        write_slot_nxt = write_slot_r + SLOT_W'(1);
      end
      // Once full, the count stays at capacity and the oldest record slides.
      if (!full) begin
        record_total_nxt = record_total_r + CNT_W'(1);
      end else if (oldest_slot_r == SLOT_W'(SLOTS - 1)) begin
        oldest_slot_nxt  = '0;
        oldest_block_nxt = oldest_block_r + BLK_W'(1);
      end else begin
        oldest_slot_nxt = oldest_slot_r + SLOT_W'(1);
      end
    end else if (in_range) begin
      res.ok      = 1'b1;
      res.address = ADDR_W'({look_blk, look_slot, REC_W'(0)});
    end

    res.record_count = COUNT_W'(record_total_nxt);
    res.remaining    = (record_total_nxt == CNT_W'(CAPACITY)) ? '0 :
                       COUNT_W'(CNT_W'(CAPACITY) - record_total_nxt);
  end

endmodule
